[sv/phs_pkg.sv]
// phs_pkg: shared types and constants for the program header scanner
// no dependencies; used by phs_parser, phs_out_reg and the top level
package phs_pkg;

	localparam int ADDR_BITS_DEF = 24;  // default width of the stream position
	localparam int ADDR_BITS_MAX = 32;
	localparam int FOUND_W       = 24;

	localparam logic [7:0]  MAGIC_RESET = 8'hFC;
	localparam logic [23:0] BASE_RESET  = 24'h0C0000;

	// configuration register byte addresses
	localparam int         PADDR_W    = 3;
	localparam logic [2:0] ADDR_MAGIC = 3'h0;
	localparam logic [2:0] ADDR_BASE  = 3'h4;

	// one parsed header, first field in the highest bits
	typedef struct packed {
		logic [15:0] payload_length;
		logic [7:0]  name_length;
		logic [7:0]  block_number;
		logic [15:0] code_offset;
		logic [7:0]  format_version;
		logic [7:0]  secondary_kind;
		logic [7:0]  program_kind;
		logic [15:0] body_length;
		logic [23:0] found_address;
	} hdr_rec_t;

	localparam int REC_W = $bits(hdr_rec_t);

	// configuration seen by the parser
	typedef struct packed {
		logic [7:0]  magic;
		logic [23:0] base;
	} scan_cfg_t;

endpackage

[sv/phs_parser.sv]
// phs_parser: byte-wide header parser state machine and field registers
// depends on phs_pkg
module phs_parser #(
	parameter int ADDRESS_BITS = phs_pkg::ADDR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                scan_start,
	input  phs_pkg::scan_cfg_t  cfg,
	output logic                emit,
	output phs_pkg::hdr_rec_t   rec
);
	import phs_pkg::*;

	localparam logic [3:0] PH_SEARCH  = 4'd0;
	localparam logic [3:0] PH_LEN_LO  = 4'd1;
	localparam logic [3:0] PH_LEN_HI  = 4'd2;
	localparam logic [3:0] PH_KIND    = 4'd3;
	localparam logic [3:0] PH_SEC     = 4'd4;
	localparam logic [3:0] PH_VER     = 4'd5;
	localparam logic [3:0] PH_OFF_LO  = 4'd6;
	localparam logic [3:0] PH_OFF_HI  = 4'd7;
	localparam logic [3:0] PH_BLOCK   = 4'd8;
	localparam logic [3:0] PH_NAMELEN = 4'd9;
	localparam logic [3:0] PH_NAME    = 4'd10;
	localparam logic [3:0] PH_PAY_LO  = 4'd11;
	localparam logic [3:0] PH_PAY_HI  = 4'd12;
	localparam logic [3:0] PH_SKIP    = 4'd13;

	logic [3:0]              phase_q, phase_d, phase_e;
	logic [ADDRESS_BITS-1:0] pos_q, pos_d, pos_e;
	logic [ADDRESS_BITS-1:0] rec_addr_q, rec_addr_d;
	logic [7:0]              name_cnt_q, name_cnt_d;
	logic [15:0]             skip_q, skip_d;
	logic [15:0]             body_len_q, body_len_d;
	logic [7:0]              kind_q, kind_d;
	logic [7:0]              sec_q, sec_d;
	logic [7:0]              ver_q, ver_d;
	logic [15:0]             offset_q, offset_d;
	logic [7:0]              block_q, block_d;
	logic [7:0]              name_len_q, name_len_d;
	logic [7:0]              pay_lo_q, pay_lo_d;
	logic [15:0]             pay_len;
	logic [ADDR_BITS_MAX-1:0] addr_sum;
	logic [ADDRESS_BITS-1:0]  addr_wrap;
	logic [ADDR_BITS_MAX-1:0] addr_ext;

	// scan start restarts the parser ahead of this byte
	assign phase_e = scan_start ? PH_SEARCH : phase_q;
	assign pos_e   = scan_start ? '0 : pos_q;
	assign pay_len = {data_byte, pay_lo_q};
	assign emit    = (phase_e == PH_PAY_HI);

	// base plus magic position, wrapped to the position width
	assign addr_sum  = ADDR_BITS_MAX'(cfg.base) + ADDR_BITS_MAX'(rec_addr_q);
	assign addr_wrap = addr_sum[ADDRESS_BITS-1:0];
	assign addr_ext  = ADDR_BITS_MAX'(addr_wrap);

	always_comb begin
		rec.found_address  = addr_ext[FOUND_W-1:0];
		rec.body_length    = body_len_q;
		rec.program_kind   = kind_q;
		rec.secondary_kind = sec_q;
		rec.format_version = ver_q;
		rec.code_offset    = offset_q;
		rec.block_number   = block_q;
		rec.name_length    = name_len_q;
		rec.payload_length = pay_len;
	end

	always_comb begin
		phase_d    = phase_e;
		pos_d      = pos_e + ADDRESS_BITS'(1);
		rec_addr_d = rec_addr_q;
		name_cnt_d = name_cnt_q;
		skip_d     = skip_q;
		body_len_d = body_len_q;
		kind_d     = kind_q;
		sec_d      = sec_q;
		ver_d      = ver_q;
		offset_d   = offset_q;
		block_d    = block_q;
		name_len_d = name_len_q;
		pay_lo_d   = pay_lo_q;
		case (phase_e)
			PH_SEARCH: begin
				if (data_byte == cfg.magic) begin
					rec_addr_d = pos_e;
					phase_d    = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				body_len_d = {8'h00, data_byte};
				phase_d    = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				body_len_d = {data_byte, body_len_q[7:0]};
				phase_d    = PH_KIND;
			end
			PH_KIND: begin
				kind_d  = data_byte;
				phase_d = PH_SEC;
			end
			PH_SEC: begin
				sec_d   = data_byte;
				phase_d = PH_VER;
			end
			PH_VER: begin
				ver_d   = data_byte;
				phase_d = PH_OFF_LO;
			end
			PH_OFF_LO: begin
				offset_d = {8'h00, data_byte};
				phase_d  = PH_OFF_HI;
			end
			PH_OFF_HI: begin
				offset_d = {data_byte, offset_q[7:0]};
				phase_d  = PH_BLOCK;
			end
			PH_BLOCK: begin
				block_d = data_byte;
				phase_d = PH_NAMELEN;
			end
			PH_NAMELEN: begin
				name_len_d = data_byte;
				name_cnt_d = data_byte;
				phase_d    = (data_byte == 8'h00) ? PH_PAY_LO : PH_NAME;
			end
			PH_NAME: begin
				name_cnt_d = name_cnt_q - 8'd1;
				if (name_cnt_q == 8'd1) begin
					phase_d = PH_PAY_LO;
				end
			end
			PH_PAY_LO: begin
				pay_lo_d = data_byte;
				phase_d  = PH_PAY_HI;
			end
			PH_PAY_HI: begin
				skip_d  = pay_len;
				phase_d = (pay_len == 16'h0000) ? PH_SEARCH : PH_SKIP;
			end
			PH_SKIP: begin
				skip_d = skip_q - 16'd1;
				if (skip_q == 16'd1) begin
					phase_d = PH_SEARCH;
				end
			end
			default: begin
				phase_d = PH_SEARCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEARCH;
			pos_q      <= '0;
			rec_addr_q <= '0;
			name_cnt_q <= '0;
			skip_q     <= '0;
			body_len_q <= '0;
			kind_q     <= '0;
			sec_q      <= '0;
			ver_q      <= '0;
			offset_q   <= '0;
			block_q    <= '0;
			name_len_q <= '0;
			pay_lo_q   <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			rec_addr_q <= rec_addr_d;
			name_cnt_q <= name_cnt_d;
			skip_q     <= skip_d;
			body_len_q <= body_len_d;
			kind_q     <= kind_d;
			sec_q      <= sec_d;
			ver_q      <= ver_d;
			offset_q   <= offset_d;
			block_q    <= block_d;
			name_len_q <= name_len_d;
			pay_lo_q   <= pay_lo_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(step && scan_start) |=> (phase_q == PH_SEARCH || phase_q == PH_LEN_LO))
		else $error("scan start did not restart the parser");

	a_start_position: assert property (@(posedge clk) disable iff (!arst_n)
		(step && scan_start) |=> (pos_q == ADDRESS_BITS'(1)))
		else $error("position not restarted by scan start");

	a_skip_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !scan_start && phase_q == PH_SKIP && skip_q == 16'd1)
		|=> (phase_q == PH_SEARCH))
		else $error("body skip did not return to search");

	a_emit_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit) |=> !(phase_q == PH_PAY_HI))
		else $error("header end held after emit");
`endif

endmodule

[sv/phs_out_reg.sv]
// phs_out_reg: result register toward the output stream
// depends on phs_pkg
module phs_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  phs_pkg::hdr_rec_t  rec_in,
	input  logic               take,
	output logic               free,
	output logic               valid,
	output phs_pkg::hdr_rec_t  rec_out
);
	import phs_pkg::*;

	logic     valid_q;
	hdr_rec_t rec_q;

	assign free    = !valid_q || take;
	assign valid   = valid_q;
	assign rec_out = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec_in;
		end
	end

`ifndef NO_ASSERTIONS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("result overwritten before transfer");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded result not marked valid");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && take && !load) |=> !valid_q)
		else $error("taken result still valid");
`endif

endmodule

[sv/program_header_scanner_unit.sv]
// program_header_scanner_unit: top level of the program header scanner
// depends on phs_pkg, phs_parser and phs_out_reg
//
// Scans a byte stream for the magic byte and parses the program header that
// follows it: body length, kind, secondary kind, version, code offset, block,
// name length, the name (skipped) and the binary length. One record leaves on
// the master side on the byte that completes a header, carrying the absolute
// address of the magic byte (base_address plus stream position, wrapped to
// ADDRESS_BITS). The binary body is then skipped in full and the search
// resumes. A byte with tuser set restarts position and parser; a record cut
// off that way is dropped. Throughput is one byte per clock: a byte lands in
// an input register, the parser state machine consumes it and a finished
// record moves into the output register. A transfer stalls only when a
// record must be written while the output register still holds one that the
// sink has not taken.
// Configuration (APB, byte address 0: magic byte, 4: base address) must be
// written while no bytes are in flight.
module program_header_scanner_unit #(
	parameter int ADDRESS_BITS = phs_pkg::ADDR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// byte stream in
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] data_byte
	input  logic                         s_tuser,   // [0] scan_start
	// header records out
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [phs_pkg::REC_W-1:0]    m_tdata,   // found_address, body_length,
	                                                // program_kind, secondary_kind,
	                                                // format_version, code_offset,
	                                                // block_number, name_length,
	                                                // payload_length
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [phs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import phs_pkg::*;

	// configuration registers
	logic [7:0]  magic_q;
	logic [23:0] base_q;
	logic        cfg_wr;
	scan_cfg_t   cfg;

	// input stage
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        start_s1;

	// parser and output hand-off
	logic        emit;
	logic        advance;
	logic        out_free;
	logic        load_out;
	hdr_rec_t    rec_new;
	hdr_rec_t    rec_out;

	// apb: always ready, write on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
			base_q  <= BASE_RESET;
		end else if (cfg_wr) begin
			case (paddr)
				ADDR_MAGIC: magic_q <= pwdata[7:0];
				ADDR_BASE:  base_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_MAGIC: prdata = {24'h000000, magic_q};
			ADDR_BASE:  prdata = {8'h00, base_q};
			default:    prdata = 32'h0000_0000;
		endcase
	end

	assign cfg.magic = magic_q;
	assign cfg.base  = base_q;

	// the held byte steps the parser unless its record has nowhere to go
	assign advance  = valid_s1 && (!emit || out_free);
	assign load_out = advance && emit;
	assign s_tready = !valid_s1 || advance;

	// input register: refilled whenever the held byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	phs_parser #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (data_s1),
		.scan_start (start_s1),
		.cfg        (cfg),
		.emit       (emit),
		.rec        (rec_new)
	);

	phs_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load_out),
		.rec_in  (rec_new),
		.take    (m_tready),
		.free    (out_free),
		.valid   (m_tvalid),
		.rec_out (rec_out)
	);

	assign m_tdata = rec_out;

`ifndef NO_ASSERTIONS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1) && $stable(start_s1)))
		else $error("held byte lost while stalled");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted byte not captured");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (emit && m_tvalid && !m_tready))
		else $error("stall without a blocked record");
`endif

endmodule
